>>> src/pbfl_pkg.sv
// ----------------------------------------------------------------------------
// pbfl_pkg
// Shared types and constants for the packet buffer free list allocator.
// ----------------------------------------------------------------------------
package pbfl_pkg;

    localparam int POOL_SLOTS = 256;
    localparam int SLOT_W     = $clog2(POOL_SLOTS);
    localparam int LINK_W     = SLOT_W + 1;
    localparam int INDEX_W    = 8;
    localparam int STATUS_W   = 2;

    typedef logic [SLOT_W-1:0]   t_slot;
    typedef logic [LINK_W-1:0]   t_link;
    typedef logic [INDEX_W-1:0]  t_index;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_link LINK_NONE = t_link'(POOL_SLOTS);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam t_status ST_OK           = 2'd0;
    localparam t_status ST_NO_MEMORY    = 2'd1;
    localparam t_status ST_ALREADY_FREE = 2'd2;

    typedef struct packed {
        logic  used;
        t_link next_link;
    } t_entry;

endpackage

>>> src/pbfl_req_if.sv
// ----------------------------------------------------------------------------
// pbfl_req_if
// Request channel: allocate or free operation with a slot index.
// ----------------------------------------------------------------------------
interface pbfl_req_if;
    import pbfl_pkg::*;

    logic   valid;
    logic   ready;
    logic   operation;
    t_index slot_index;

    modport source (output valid, output operation, output slot_index, input ready);
    modport sink   (input valid, input operation, input slot_index, output ready);
endinterface

>>> src/pbfl_rsp_if.sv
// ----------------------------------------------------------------------------
// pbfl_rsp_if
// Response channel: status and granted slot of one request.
// ----------------------------------------------------------------------------
interface pbfl_rsp_if;
    import pbfl_pkg::*;

    logic    valid;
    logic    ready;
    t_status status;
    t_index  granted_slot;

    modport source (output valid, output status, output granted_slot, input ready);
    modport sink   (input valid, input status, input granted_slot, output ready);
endinterface

>>> src/pbfl_slot_table.sv
// ----------------------------------------------------------------------------
// pbfl_slot_table
// Per-slot in-use mark and next link in one synchronous memory. Valid bits
// stand in for the reset image: an unwritten slot reads as free, linked to
// the slot after it.
// ----------------------------------------------------------------------------
module pbfl_slot_table (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rd_en,
    input  pbfl_pkg::t_slot i_rd_addr,
    input  logic            i_wr_en,
    input  pbfl_pkg::t_slot i_wr_addr,
    input  pbfl_pkg::t_entry i_wr_data,
    output pbfl_pkg::t_entry o_rd_data
);
    import pbfl_pkg::*;

    t_entry                r_mem [POOL_SLOTS];
    logic [POOL_SLOTS-1:0] r_vld;
    t_entry                r_rd_data;
    logic                  r_rd_vld;
    t_slot                 r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    // unwritten slot: free, linked to the next slot (last slot links to none)
    always_comb begin
        if (r_rd_vld) begin
            o_rd_data = r_rd_data;
        end else begin
            o_rd_data.used      = 1'b0;
            o_rd_data.next_link = {1'b0, r_rd_addr} + t_link'(1);
        end
    end

endmodule

>>> src/packet_buffer_free_list.sv
// ----------------------------------------------------------------------------
// packet_buffer_free_list
// Allocator for a fixed pool of packet buffer slots kept on a linked free list.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request per transfer: operation 0 allocates the slot at
//   the head of the free list, operation 1 returns slot_index to the list.
//   o_rsp carries exactly one result per request: status 0 success, 1 out of
//   memory (list empty), 2 slot already free; granted_slot holds the slot on
//   a successful allocate and zero otherwise.
//   A request is handled in order: the transfer cycle issues a read of the
//   slot table, the execute state takes the registered read data, writes the
//   entry back and loads the result register. A new request is taken only
//   once the current one has finished, since ready is high only in the idle
//   state. The result is registered: o_rsp.valid rises once the execute state
//   finishes, and the result can transfer from then on.
//   Reset (synchronous, active low) empties the result register, points the
//   head at slot 0 and marks every slot free and linked in order, with no
//   clearing pass.
//   A waiting result holds while the receiver stalls; one more request is
//   taken meanwhile and finishes once the result register is free.
// ----------------------------------------------------------------------------
module packet_buffer_free_list (
    input  logic i_clk,
    input  logic i_rst_n,
    pbfl_req_if.sink   i_req,
    pbfl_rsp_if.source o_rsp
);
    import pbfl_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic    r_state;
    logic    r_op;
    t_slot   r_addr;
    t_link   r_head;
    logic    r_out_valid;
    t_status r_status;
    t_index  r_granted;

    logic    n_state;
    t_link   n_head;
    logic    n_out_valid;
    t_status n_status;
    t_index  n_granted;

    logic    accept;
    logic    finish;
    t_slot   rd_addr;
    logic    wr_en;
    t_entry  wr_data;
    t_entry  rd_data;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign finish      = (r_state == S_EXEC) && (!r_out_valid || o_rsp.ready);
    assign rd_addr     = (i_req.operation == OP_FREE) ? t_slot'(i_req.slot_index)
                                                      : r_head[SLOT_W-1:0];

    pbfl_slot_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_status    = r_status;
        n_granted   = r_granted;
        wr_en       = 1'b0;
        wr_data     = rd_data;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (finish) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_granted   = '0;
                    if (r_op == OP_ALLOC) begin
                        if (r_head == LINK_NONE) begin
                            n_status = ST_NO_MEMORY;
                        end else begin
                            n_status     = ST_OK;
                            n_granted    = t_index'(r_addr);
                            n_head       = rd_data.next_link;
                            wr_en        = 1'b1;
                            wr_data.used = 1'b1;
                        end
                    end else begin
                        if (!rd_data.used) begin
                            n_status = ST_ALREADY_FREE;
                        end else begin
                            n_status          = ST_OK;
                            n_head            = {1'b0, r_addr};
                            wr_en             = 1'b1;
                            wr_data.used      = 1'b0;
                            wr_data.next_link = r_head;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_req.operation;
            r_addr <= rd_addr;
        end
        r_status  <= n_status;
        r_granted <= n_granted;
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.granted_slot = r_granted;

endmodule

>>> src/pbfl_checker.sv
// ----------------------------------------------------------------------------
// pbfl_checker
// Port-level checks on the free list allocator, bound to the top level.
// ----------------------------------------------------------------------------
module pbfl_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_req_valid,
    input logic             i_req_ready,
    input logic             i_rsp_valid,
    input logic             i_rsp_ready,
    input pbfl_pkg::t_status i_rsp_status,
    input pbfl_pkg::t_index  i_rsp_granted
);
    import pbfl_pkg::*;

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_status == ST_OK || i_rsp_status == ST_NO_MEMORY ||
                         i_rsp_status == ST_ALREADY_FREE))
        else $error("undefined status code");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status != ST_OK |-> i_rsp_granted == '0)
        else $error("failed request carries a slot");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while another is in progress");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

endmodule

bind packet_buffer_free_list pbfl_checker u_pbfl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_status  (o_rsp.status),
    .i_rsp_granted (o_rsp.granted_slot)
);
